/* hdl/tsq_pkg.sv */
// Shared types and constants for the touch sample qualifier.
// Used by the sort cells, the sort chain and the top level.
`default_nettype none

package tsq_pkg;

  localparam int SAMPLES = 5;
  localparam int TRIM    = 1;

  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 16;
  localparam int GAIN_W   = 24;
  localparam int OFF_W    = 20;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(SAMPLES);
  localparam int KEEP   = (SAMPLES > 2 * TRIM) ? SAMPLES - 2 * TRIM : 1;
  localparam int DIV_SH = SUM_W + 4;
  localparam int RECIP_W = DIV_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SH) + KEEP - 1) / KEEP);

  localparam logic [SAMPLE_W-1:0] AGREE_RESET = 12'd50;
  localparam logic [POS_W-1:0]    IDLE_POS    = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AGREE_WIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET  = 3'd6;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]    pos_t;

  typedef struct packed {
    logic    moves;
    sample_t val;
  } cell_link_t;

endpackage

`default_nettype wire

/* hdl/tsq_sort_cell.sv */
// One cell of the insertion sorter: holds one sample of a reading.
// Depends on tsq_pkg for the sample and link types.
`default_nettype none

module tsq_sort_cell
  import tsq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       ins,
  input  wire sample_t    new_val,
  input  wire logic       occ,
  input  wire cell_link_t left,
  output cell_link_t      right
);

  sample_t val;
  logic    moves;

  assign moves = !occ || (new_val < val);
  assign right = '{moves: moves, val: val};

  always_ff @(posedge clk) begin
    if (ins) begin
      if (left.moves) begin
        val <= left.val;
      end else if (moves) begin
        val <= new_val;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/tsq_sort_chain.sv */
// Row of sort cells for one axis; keeps the current reading in order.
// Depends on tsq_pkg and tsq_sort_cell.
`default_nettype none

module tsq_sort_chain
  import tsq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 ins,
  input  wire sample_t              new_val,
  input  wire logic [CNT_W-1:0]     count,
  output sample_t [SAMPLES-1:0]     vals
);

  cell_link_t links [SAMPLES];

  for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
    cell_link_t left;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = links[i-1];
    end

    tsq_sort_cell u_cell (
      .clk     (clk),
      .ins     (ins),
      .new_val (new_val),
      .occ     (CNT_W'(i) < count),
      .left    (left),
      .right   (links[i])
    );

    assign vals[i] = links[i].val;
  end

endmodule

`default_nettype wire

/* hdl/touch_sample_qualifier.sv */
// Top level of the touch sample qualifier: sequencer, averaging, scaling, press state.
// Depends on tsq_pkg and tsq_sort_chain.
//
// Each pen-down beat carries one X/Y sample pair, inserted in order into a row of sort
// cells per axis; five pairs make a reading, the middle three are averaged, and two
// readings make a scan. A beat in the middle of a reading is inserted and the sequencer
// stays idle. The beat that ends the first reading of a scan goes through insert, sum,
// divide and store. The beat that ends a scan goes through the sum, reciprocal-multiply,
// compare, gain-multiply, saturate, press and emit steps of the sequencer; raw mode or
// disagreement skips gain-multiply and saturate. A pen-up beat goes to emit. One result
// is held in an output register, so the next beat is taken while a result waits; the
// sequencer stalls only when a second result is ready before the first is taken.
`default_nettype none

module touch_sample_qualifier
  import tsq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 pen_down,
  input  wire logic [11:0]          raw_x,
  input  wire logic [11:0]          raw_y,
  input  wire logic                 clear_caught,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      pressed,
  output logic                      caught,
  output logic                      readings_agreed,
  output logic [15:0]               pos_x,
  output logic [15:0]               pos_y,
  output logic [15:0]               first_x,
  output logic [15:0]               first_y
);

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_DIV, S_CHECK, S_SCALE, S_SAT, S_PRESS, S_EMIT
  } state_t;

  localparam int PROD_W = GAIN_W + SAMPLE_W + 1;
  localparam int ACC_W  = PROD_W + 1;
  localparam int MUL_W  = SUM_W + RECIP_W;

  state_t state;

  logic                raw_mode;
  logic                swap_axes;
  sample_t             agree_window;
  logic [GAIN_W-1:0]   x_gain;
  logic [OFF_W-1:0]    x_offset;
  logic [GAIN_W-1:0]   y_gain;
  logic [OFF_W-1:0]    y_offset;

  logic [CNT_W-1:0]    count;
  logic                reading_index;
  sample_t             first_rd_x;
  sample_t             first_rd_y;
  pos_t                position_x;
  pos_t                position_y;
  pos_t                start_x;
  pos_t                start_y;
  logic                press_flag;
  logic                caught_flag;
  logic                agreed;

  logic [SUM_W-1:0]    sum_x;
  logic [SUM_W-1:0]    sum_y;
  sample_t             rd_x;
  sample_t             rd_y;
  sample_t             avg_x;
  sample_t             avg_y;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;

  logic                accept;
  logic                ins;
  sample_t             samp_x;
  sample_t             samp_y;
  sample_t [SAMPLES-1:0] vals_x;
  sample_t [SAMPLES-1:0] vals_y;
  logic [SUM_W-1:0]    sum_x_next;
  logic [SUM_W-1:0]    sum_y_next;
  logic [MUL_W-1:0]    mul_x;
  logic [MUL_W-1:0]    mul_y;
  sample_t             diff_x;
  sample_t             diff_y;
  logic                agree_now;
  logic [SAMPLE_W:0]   pair_x;
  logic [SAMPLE_W:0]   pair_y;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  pos_t                sat_x;
  pos_t                sat_y;
  logic [CNT_W-1:0]    count_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ins      = accept && pen_down;
  assign samp_x   = swap_axes ? raw_y : raw_x;
  assign samp_y   = swap_axes ? raw_x : raw_y;
  assign count_next = count + CNT_W'(1);

  tsq_sort_chain u_chain_x (
    .clk     (clk),
    .ins     (ins),
    .new_val (samp_x),
    .count   (count),
    .vals    (vals_x)
  );

  tsq_sort_chain u_chain_y (
    .clk     (clk),
    .ins     (ins),
    .new_val (samp_y),
    .count   (count),
    .vals    (vals_y)
  );

  always_comb begin
    sum_x_next = '0;
    sum_y_next = '0;
    for (int i = TRIM; i < SAMPLES - TRIM; i++) begin
      sum_x_next = sum_x_next + SUM_W'(vals_x[i]);
      sum_y_next = sum_y_next + SUM_W'(vals_y[i]);
    end
  end

  assign mul_x = MUL_W'(sum_x) * MUL_W'(RECIP);
  assign mul_y = MUL_W'(sum_y) * MUL_W'(RECIP);

  assign diff_x = (first_rd_x > rd_x) ? first_rd_x - rd_x : rd_x - first_rd_x;
  assign diff_y = (first_rd_y > rd_y) ? first_rd_y - rd_y : rd_y - first_rd_y;
  assign agree_now = (diff_x < agree_window) && (diff_y < agree_window);
  assign pair_x = {1'b0, first_rd_x} + {1'b0, rd_x};
  assign pair_y = {1'b0, first_rd_y} + {1'b0, rd_y};

  assign acc_x = ACC_W'(prod_x) + (ACC_W'(signed'(x_offset)) <<< 16);
  assign acc_y = ACC_W'(prod_y) + (ACC_W'(signed'(y_offset)) <<< 16);

  always_comb begin
    if (acc_x[ACC_W-1]) begin
      sat_x = '0;
    end else if (|acc_x[ACC_W-2:20+POS_W]) begin
      sat_x = IDLE_POS;
    end else begin
      sat_x = acc_x[20 +: POS_W];
    end
    if (acc_y[ACC_W-1]) begin
      sat_y = '0;
    end else if (|acc_y[ACC_W-2:20+POS_W]) begin
      sat_y = IDLE_POS;
    end else begin
      sat_y = acc_y[20 +: POS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      raw_mode      <= 1'b0;
      swap_axes     <= 1'b0;
      agree_window  <= AGREE_RESET;
      x_gain        <= '0;
      x_offset      <= '0;
      y_gain        <= '0;
      y_offset      <= '0;
      count         <= '0;
      reading_index <= 1'b0;
      first_rd_x    <= '0;
      first_rd_y    <= '0;
      position_x    <= '0;
      position_y    <= '0;
      start_x       <= '0;
      start_y       <= '0;
      press_flag    <= 1'b0;
      caught_flag   <= 1'b0;
      agreed        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RAW_MODE:  raw_mode     <= cfg_data[0];
          REG_SWAP_AXES: swap_axes    <= cfg_data[0];
          REG_AGREE_WIN: agree_window <= cfg_data[SAMPLE_W-1:0];
          REG_X_GAIN:    x_gain       <= cfg_data[GAIN_W-1:0];
          REG_X_OFFSET:  x_offset     <= cfg_data[OFF_W-1:0];
          REG_Y_GAIN:    y_gain       <= cfg_data[GAIN_W-1:0];
          REG_Y_OFFSET:  y_offset     <= cfg_data[OFF_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            agreed <= 1'b0;
            if (clear_caught) begin
              caught_flag <= 1'b0;
            end
            if (pen_down) begin
              if (count_next == CNT_W'(SAMPLES)) begin
                count <= '0;
                state <= S_SUM;
              end else begin
                count <= count_next;
              end
            end else begin
              count         <= '0;
              reading_index <= 1'b0;
              if (press_flag) begin
                press_flag <= 1'b0;
              end else begin
                start_x    <= '0;
                start_y    <= '0;
                position_x <= IDLE_POS;
                position_y <= IDLE_POS;
              end
              state <= S_EMIT;
            end
          end
        end
        S_SUM: begin
          sum_x <= sum_x_next;
          sum_y <= sum_y_next;
          state <= S_DIV;
        end
        S_DIV: begin
          rd_x  <= mul_x[DIV_SH +: SAMPLE_W];
          rd_y  <= mul_y[DIV_SH +: SAMPLE_W];
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!reading_index) begin
            first_rd_x    <= rd_x;
            first_rd_y    <= rd_y;
            reading_index <= 1'b1;
            state         <= S_IDLE;
          end else begin
            reading_index <= 1'b0;
            agreed        <= agree_now;
            avg_x         <= pair_x[SAMPLE_W:1];
            avg_y         <= pair_y[SAMPLE_W:1];
            if (agree_now && raw_mode) begin
              position_x <= POS_W'(pair_x[SAMPLE_W:1]);
              position_y <= POS_W'(pair_y[SAMPLE_W:1]);
              state      <= S_PRESS;
            end else if (agree_now) begin
              state <= S_SCALE;
            end else begin
              state <= S_PRESS;
            end
          end
        end
        S_SCALE: begin
          prod_x <= signed'(x_gain) * signed'({1'b0, avg_x});
          prod_y <= signed'(y_gain) * signed'({1'b0, avg_y});
          state  <= S_SAT;
        end
        S_SAT: begin
          position_x <= sat_x;
          position_y <= sat_y;
          state      <= S_PRESS;
        end
        S_PRESS: begin
          if (!press_flag) begin
            press_flag  <= 1'b1;
            caught_flag <= 1'b1;
            start_x     <= position_x;
            start_y     <= position_y;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            pressed         <= press_flag;
            caught          <= caught_flag;
            readings_agreed <= agreed;
            pos_x           <= position_x;
            pos_y           <= position_y;
            first_x         <= start_x;
            first_y         <= start_y;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/touch_sample_qualifier_chk.sv */
`timescale 1ns / 100ps
// Scoreboard for the touch sample qualifier: tracks register writes and accepted beats,
// predicts each touch report and compares it with what the block hands out.
// Depends on tsq_pkg.

module touch_sample_qualifier_chk
  import tsq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic                 pen_down,
  input  wire logic [11:0]          raw_x,
  input  wire logic [11:0]          raw_y,
  input  wire logic                 clear_caught,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic                 pressed,
  input  wire logic                 caught,
  input  wire logic                 readings_agreed,
  input  wire logic [15:0]          pos_x,
  input  wire logic [15:0]          pos_y,
  input  wire logic [15:0]          first_x,
  input  wire logic [15:0]          first_y,
  output int                        mismatches,
  output int                        awaiting
);

  localparam int KEEP_N = SAMPLES - 2 * TRIM;

  typedef struct packed {
    logic pressed;
    logic caught;
    logic agreed;
    pos_t pos_x;
    pos_t pos_y;
    pos_t first_x;
    pos_t first_y;
  } touch_report_t;

  logic                     raw_mode_r;
  logic                     swap_r;
  sample_t                  window_r;
  logic signed [GAIN_W-1:0] gain_x_r;
  logic signed [GAIN_W-1:0] gain_y_r;
  logic signed [OFF_W-1:0]  off_x_r;
  logic signed [OFF_W-1:0]  off_y_r;

  sample_t       row_x [SAMPLES];
  sample_t       row_y [SAMPLES];
  int unsigned   fill;
  logic          have_first;
  sample_t       first_rd_x;
  sample_t       first_rd_y;
  pos_t          cur_x;
  pos_t          cur_y;
  pos_t          start_x;
  pos_t          start_y;
  logic          press_r;
  logic          caught_r;
  touch_report_t reports_due [$];

  function automatic sample_t trimmed_mean(input logic y_axis);
    sample_t     t [SAMPLES];
    sample_t     v;
    int          j;
    int unsigned total;
    for (int i = 0; i < SAMPLES; i++) t[i] = y_axis ? row_y[i] : row_x[i];
    for (int i = 1; i < SAMPLES; i++) begin
      v = t[i];
      j = i;
      while (j > 0 && t[j-1] > v) begin
        t[j] = t[j-1];
        j--;
      end
      t[j] = v;
    end
    if (SAMPLES <= 2 * TRIM) return '0;
    total = 0;
    for (int i = TRIM; i < SAMPLES - TRIM; i++) total += t[i];
    return sample_t'(total / KEEP_N);
  endfunction

  function automatic logic within_window(input sample_t a, input sample_t b);
    sample_t d;
    d = (a > b) ? a - b : b - a;
    return d < window_r;
  endfunction

  // Q3.20 gain times reading plus Q15.4 offset, truncated and clamped to 0..65535
  function automatic pos_t calibrate(input sample_t v, input logic signed [GAIN_W-1:0] g,
                                     input logic signed [OFF_W-1:0] o);
    longint acc;
    acc = longint'(g) * longint'({1'b0, v}) + longint'(o) * 65536;
    if (acc < 0) return '0;
    acc = acc >>> 20;
    if (acc > 65535) return '1;
    return pos_t'(acc);
  endfunction

  function automatic void take_beat(input logic pd, input sample_t x, input sample_t y,
                                    input logic cc);
    sample_t       sx;
    sample_t       sy;
    sample_t       ax;
    sample_t       ay;
    sample_t       mx;
    sample_t       my;
    logic          agreed;
    touch_report_t r;
    agreed = 1'b0;
    if (cc) caught_r = 1'b0;
    if (pd) begin
      sx = swap_r ? y : x;
      sy = swap_r ? x : y;
      if (fill >= SAMPLES) fill = 0;
      row_x[fill] = sx;
      row_y[fill] = sy;
      fill++;
      if (fill < SAMPLES) return;
      fill = 0;
      ax = trimmed_mean(1'b0);
      ay = trimmed_mean(1'b1);
      if (!have_first) begin
        first_rd_x = ax;
        first_rd_y = ay;
        have_first = 1'b1;
        return;
      end
      have_first = 1'b0;
      if (within_window(first_rd_x, ax) && within_window(first_rd_y, ay)) begin
        agreed = 1'b1;
        mx = sample_t'((int'(first_rd_x) + int'(ax)) / 2);
        my = sample_t'((int'(first_rd_y) + int'(ay)) / 2);
        if (raw_mode_r) begin
          cur_x = pos_t'(mx);
          cur_y = pos_t'(my);
        end else begin
          cur_x = calibrate(mx, gain_x_r, off_x_r);
          cur_y = calibrate(my, gain_y_r, off_y_r);
        end
      end
      if (!press_r) begin
        press_r  = 1'b1;
        caught_r = 1'b1;
        start_x  = cur_x;
        start_y  = cur_y;
      end
    end else begin
      fill = 0;
      have_first = 1'b0;
      if (press_r) begin
        press_r = 1'b0;
      end else begin
        start_x = '0;
        start_y = '0;
        cur_x   = IDLE_POS;
        cur_y   = IDLE_POS;
      end
    end
    r.pressed = press_r;
    r.caught  = caught_r;
    r.agreed  = agreed;
    r.pos_x   = cur_x;
    r.pos_y   = cur_y;
    r.first_x = start_x;
    r.first_y = start_y;
    reports_due.push_back(r);
  endfunction

  task automatic flag(input string why, input touch_report_t want, input touch_report_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: pressed %b/%b caught %b/%b agreed %b/%b pos %0d,%0d/%0d,%0d first %0d,%0d/%0d,%0d (exp/act)",
               $time, why, want.pressed, seen.pressed, want.caught, seen.caught,
               want.agreed, seen.agreed, want.pos_x, want.pos_y, seen.pos_x, seen.pos_y,
               want.first_x, want.first_y, seen.first_x, seen.first_y);
  endtask

  always @(posedge clk) begin : monitor
    touch_report_t seen;
    touch_report_t want;
    if (rst) begin
      raw_mode_r = 1'b0;
      swap_r     = 1'b0;
      window_r   = AGREE_RESET;
      gain_x_r   = '0;
      gain_y_r   = '0;
      off_x_r    = '0;
      off_y_r    = '0;
      fill       = 0;
      have_first = 1'b0;
      first_rd_x = '0;
      first_rd_y = '0;
      cur_x      = '0;
      cur_y      = '0;
      start_x    = '0;
      start_y    = '0;
      press_r    = 1'b0;
      caught_r   = 1'b0;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RAW_MODE:  raw_mode_r = cfg_data[0];
          REG_SWAP_AXES: swap_r     = cfg_data[0];
          REG_AGREE_WIN: window_r   = cfg_data[SAMPLE_W-1:0];
          REG_X_GAIN:    gain_x_r   = cfg_data[GAIN_W-1:0];
          REG_X_OFFSET:  off_x_r    = cfg_data[OFF_W-1:0];
          REG_Y_GAIN:    gain_y_r   = cfg_data[GAIN_W-1:0];
          REG_Y_OFFSET:  off_y_r    = cfg_data[OFF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_beat(pen_down, raw_x, raw_y, clear_caught);
      if (out_valid && out_ready) begin
        seen.pressed = pressed;
        seen.caught  = caught;
        seen.agreed  = readings_agreed;
        seen.pos_x   = pos_x;
        seen.pos_y   = pos_y;
        seen.first_x = first_x;
        seen.first_y = first_y;
        if (reports_due.size() == 0) begin
          flag("report with none pending", seen, seen);
        end else begin
          want = reports_due.pop_front();
          if (want !== seen) flag("report mismatch", want, seen);
        end
      end
    end
    awaiting = reports_due.size();
  end

endmodule

/* tb/touch_sample_qualifier_tb.sv */
`timescale 1ns / 100ps
// Top of the touch sample qualifier testbench: clock, reset, register setup, beat stimulus
// with random gaps and back-pressure, watchdog and verdict.
// Depends on tsq_pkg, touch_sample_qualifier and touch_sample_qualifier_chk.

module touch_sample_qualifier_tb;
  import tsq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int IDLE_LIMIT      = 1000;
  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 120;
  localparam int SETTLE          = 12;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 pen_down     = 1'b0;
  logic [11:0]          raw_x        = '0;
  logic [11:0]          raw_y        = '0;
  logic                 clear_caught = 1'b0;
  logic                 out_ready    = 1'b0;
  wire logic            in_ready;
  wire logic            out_valid;
  wire logic            pressed;
  wire logic            caught;
  wire logic            readings_agreed;
  wire logic [15:0]     pos_x;
  wire logic [15:0]     pos_y;
  wire logic [15:0]     first_x;
  wire logic [15:0]     first_y;

  int               mismatches;
  int               awaiting;
  int               beats_sent  = 0;
  int               stall_left  = 0;
  int               idle_cycles = 0;
  logic             steady_in   = 1'b0;
  logic             steady_out  = 1'b0;
  logic [CFG_W-1:0] reg_image [0:REG_SPARE];

  touch_sample_qualifier u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pen_down        (pen_down),
    .raw_x           (raw_x),
    .raw_y           (raw_y),
    .clear_caught    (clear_caught),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pressed         (pressed),
    .caught          (caught),
    .readings_agreed (readings_agreed),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .first_x         (first_x),
    .first_y         (first_y)
  );

  touch_sample_qualifier_chk u_chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pen_down        (pen_down),
    .raw_x           (raw_x),
    .raw_y           (raw_y),
    .clear_caught    (clear_caught),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pressed         (pressed),
    .caught          (caught),
    .readings_agreed (readings_agreed),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .first_x         (first_x),
    .first_y         (first_y),
    .mismatches      (mismatches),
    .awaiting        (awaiting)
  );

  always #5 clk = ~clk;

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic sample_t jitter(input sample_t base, input int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  // random bits above the register's width, which the block must drop
  function automatic logic [CFG_W-1:0] pad(input logic [CFG_W-1:0] v, input int w);
    return (CFG_W'($urandom) << w) | v;
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (!steady_out) stall_left = idle_gap();
    end
    if ($urandom_range(0, 499) == 0) steady_out = !steady_out;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic push_beat(input logic pd, input sample_t x, input sample_t y, input logic cc);
    int gap;
    gap = steady_in ? 0 : idle_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    pen_down     = pd;
    raw_x        = x;
    raw_y        = y;
    clear_caught = cc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
    if ($urandom_range(0, 199) == 0) steady_in = !steady_in;
  endtask

  task automatic push_reading(input sample_t bx, input sample_t by, input int spread,
                              input int wild);
    logic cc;
    for (int i = 0; i < SAMPLES; i++) begin
      cc = ($urandom_range(0, 9) == 0);
      if (int'($urandom_range(0, 99)) < wild)
        push_beat(1'b1, sample_t'($urandom), sample_t'($urandom), cc);
      else
        push_beat(1'b1, jitter(bx, spread), jitter(by, spread), cc);
    end
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic load_registers();
    for (int i = int'(REG_RAW_MODE); i <= int'(REG_SPARE); i++) begin
      cfg_we    = 1'b1;
      cfg_index = CFG_IDX_W'(i);
      cfg_data  = reg_image[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  initial begin : stimulus
    int      r;
    int      n;
    int      quota;
    sample_t bx;
    sample_t by;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: unity gain, default window
    reg_image[REG_RAW_MODE]  = pad(CFG_W'(0), 1);
    reg_image[REG_SWAP_AXES] = pad(CFG_W'(0), 1);
    reg_image[REG_AGREE_WIN] = pad(CFG_W'(AGREE_RESET), SAMPLE_W);
    reg_image[REG_X_GAIN]    = 24'h100000;
    reg_image[REG_X_OFFSET]  = pad(CFG_W'(0), OFF_W);
    reg_image[REG_Y_GAIN]    = 24'h100000;
    reg_image[REG_Y_OFFSET]  = pad(CFG_W'(0), OFF_W);
    reg_image[REG_SPARE]     = CFG_W'($urandom);
    load_registers();
    push_beat(1'b0, 12'h000, 12'h000, 1'b1);
    push_reading(12'd100, 12'd4000, 0, 0);
    push_reading(12'd120, 12'd3990, 0, 0);
    push_beat(1'b0, 12'hFFF, 12'hFFF, 1'b0);
    repeat (3) push_beat(1'b1, sample_t'($urandom), sample_t'($urandom), 1'b0);
    push_beat(1'b0, 12'h000, 12'hFFF, 1'b1);
    // far-apart readings: position stays idle and becomes the first press
    push_reading(12'h000, 12'h000, 0, 0);
    push_reading(12'hFFF, 12'hFFF, 0, 0);
    push_beat(1'b0, 12'hFFF, 12'h000, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      reg_image[REG_RAW_MODE]  = pad(CFG_W'($urandom_range(0, 9) < 3), 1);
      reg_image[REG_SWAP_AXES] = pad(CFG_W'($urandom_range(0, 1)), 1);
      reg_image[REG_AGREE_WIN] = pad(CFG_W'($urandom_range(1, 600)), SAMPLE_W);
      reg_image[REG_X_GAIN]    = $urandom_range(0, 1) ? CFG_W'($urandom)
                                 : CFG_W'($urandom_range(24'h040000, 24'h7FFFFF));
      reg_image[REG_Y_GAIN]    = $urandom_range(0, 1) ? CFG_W'($urandom)
                                 : CFG_W'($urandom_range(24'h040000, 24'h7FFFFF));
      reg_image[REG_X_OFFSET]  = pad(CFG_W'($urandom_range(0, 1) ? OFF_W'($urandom)
                                     : OFF_W'($urandom_range(0, 20'h03FFF))), OFF_W);
      reg_image[REG_Y_OFFSET]  = pad(CFG_W'($urandom_range(0, 1) ? OFF_W'($urandom)
                                     : OFF_W'($urandom_range(0, 20'h03FFF))), OFF_W);
      reg_image[REG_SPARE]     = CFG_W'($urandom);
      case (p)
        0: begin
          reg_image[REG_RAW_MODE]  = pad(CFG_W'(1), 1);
          reg_image[REG_SWAP_AXES] = pad(CFG_W'(1), 1);
          reg_image[REG_AGREE_WIN] = pad(CFG_W'(12'hFFF), SAMPLE_W);
        end
        1: begin
          reg_image[REG_RAW_MODE] = pad(CFG_W'(0), 1);
          reg_image[REG_X_GAIN]   = 24'h7FFFFF;
          reg_image[REG_Y_GAIN]   = 24'h7FFFFF;
          reg_image[REG_X_OFFSET] = pad(CFG_W'(20'h7FFFF), OFF_W);
          reg_image[REG_Y_OFFSET] = pad(CFG_W'(20'h7FFFF), OFF_W);
        end
        2: begin
          reg_image[REG_RAW_MODE]  = pad(CFG_W'(0), 1);
          reg_image[REG_SWAP_AXES] = pad(CFG_W'(1), 1);
          reg_image[REG_X_GAIN]    = 24'h800000;
          reg_image[REG_Y_GAIN]    = 24'h800000;
          reg_image[REG_X_OFFSET]  = pad(CFG_W'(20'h80000), OFF_W);
          reg_image[REG_Y_OFFSET]  = pad(CFG_W'(20'h80000), OFF_W);
        end
        3: begin
          reg_image[REG_RAW_MODE]  = pad(CFG_W'(0), 1);
          reg_image[REG_AGREE_WIN] = pad(CFG_W'(0), SAMPLE_W);
        end
        default: ;
      endcase
      load_registers();
      steady_in = ($urandom_range(0, 3) == 0);
      quota = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < quota) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          push_beat(1'b0, sample_t'($urandom), sample_t'($urandom), $urandom_range(0, 3) == 0);
        end else if (r < 14) begin
          n = $urandom_range(1, 2 * SAMPLES - 1);
          repeat (n)
            push_beat(1'b1, sample_t'($urandom), sample_t'($urandom),
                      $urandom_range(0, 9) == 0);
          push_beat(1'b0, sample_t'($urandom), sample_t'($urandom), $urandom_range(0, 3) == 0);
        end else begin
          bx = sample_t'($urandom);
          by = sample_t'($urandom);
          push_reading(bx, by, 6, 25);
          if ($urandom_range(0, 3) != 0)
            push_reading(jitter(bx, 30), jitter(by, 30), 6, 25);
          else
            push_reading(sample_t'($urandom), sample_t'($urandom), 6, 25);
        end
      end
      push_beat(1'b0, sample_t'($urandom), sample_t'($urandom), $urandom_range(0, 1) != 0);
    end

    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
hdl/tsq_pkg.sv
hdl/tsq_sort_cell.sv
hdl/tsq_sort_chain.sv
hdl/touch_sample_qualifier.sv
tb/touch_sample_qualifier_chk.sv
tb/touch_sample_qualifier_tb.sv
